// ----- rtl/core/kar_pkg.sv -----
package kar_pkg;

    localparam int KEY_W        = 16;
    localparam int DELAY_W      = 16;
    localparam int SLOT_IN_W    = 3;
    localparam int POS_IN_W     = 3;
    localparam int ENABLE_W     = 5;
    localparam int MASK_LOW_W   = 64;

    // Slots that have a mask and an enable bit in the register file.
    localparam int REG_SLOTS    = 5;

    localparam int DEF_NUM_SLOTS   = 5;
    localparam int DEF_TABLE_DEPTH = 8;

    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 64;

    localparam logic signed [DELAY_W-1:0] END_MARK  = -16'sd1;
    localparam logic signed [DELAY_W-1:0] COUNT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        REG_SLOT_ENABLE   = 2'd0,
        REG_KEY_MASKS_LOW = 2'd1,
        REG_KEY_MASK_LAST = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        logic [ENABLE_W-1:0]   slot_enable;
        logic [MASK_LOW_W-1:0] key_masks_low;
        logic [KEY_W-1:0]      key_mask_last;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0] held;
        logic [KEY_W-1:0] pressed;
    } pad_t;

endpackage

// ----- rtl/core/kar_cmd_if.sv -----
interface kar_cmd_if;
    import kar_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [KEY_W-1:0]          held_keys;
    logic [KEY_W-1:0]          pressed_keys;
    logic [SLOT_IN_W-1:0]      entry_slot;
    logic [POS_IN_W-1:0]       entry_position;
    logic signed [DELAY_W-1:0] entry_delay;

    modport source (
        output valid, op, held_keys, pressed_keys, entry_slot, entry_position, entry_delay,
        input  ready
    );

    modport sink (
        input  valid, op, held_keys, pressed_keys, entry_slot, entry_position, entry_delay,
        output ready
    );
endinterface

// ----- rtl/core/kar_res_if.sv -----
interface kar_res_if;
    import kar_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] trigger_out;
    logic [KEY_W-1:0] repeat_keys;

    modport source (
        output valid, trigger_out, repeat_keys,
        input  ready
    );

    modport sink (
        input  valid, trigger_out, repeat_keys,
        output ready
    );
endinterface

// ----- rtl/core/kar_cfg.sv -----
module kar_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kar_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kar_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kar_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output kar_pkg::cfg_t                 cfg
);
    import kar_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t index;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign index  = reg_index_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_SLOT_ENABLE:   cfg_reg.slot_enable   <= pwdata[ENABLE_W-1:0];
                REG_KEY_MASKS_LOW: cfg_reg.key_masks_low <= pwdata[MASK_LOW_W-1:0];
                REG_KEY_MASK_LAST: cfg_reg.key_mask_last <= pwdata[KEY_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SLOT_ENABLE:   prdata = CFG_DATA_W'(cfg_reg.slot_enable);
            REG_KEY_MASKS_LOW: prdata = CFG_DATA_W'(cfg_reg.key_masks_low);
            REG_KEY_MASK_LAST: prdata = CFG_DATA_W'(cfg_reg.key_mask_last);
            default:           prdata = '0;
        endcase
    end
endmodule

// ----- rtl/core/kar_slot.sv -----
module kar_slot #(
    parameter int TABLE_DEPTH = kar_pkg::DEF_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tick,
    input  logic                               active,
    input  logic [kar_pkg::KEY_W-1:0]          mask,
    input  kar_pkg::pad_t                      pad,
    input  logic                               wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
    input  logic signed [kar_pkg::DELAY_W-1:0] wr_data,
    output logic                               fired
);
    import kar_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(TABLE_DEPTH - 1);

    logic signed [DELAY_W-1:0] mem [TABLE_DEPTH];

    logic [PW-1:0]             pos_reg;
    logic [PW-1:0]             pos_next;
    logic signed [DELAY_W-1:0] count_reg;
    logic signed [DELAY_W-1:0] count_next;
    logic signed [DELAY_W-1:0] count_dec;
    logic signed [DELAY_W-1:0] first_reg;
    logic signed [DELAY_W-1:0] cur_reg;
    logic signed [DELAY_W-1:0] step_reg;
    logic [PW-1:0]             cur_addr;
    logic [PW-1:0]             step_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The two read registers always hold the entries at the position and the one
    // after it (the same entry at the last position), so a tick never waits for the
    // table. A write in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        cur_reg  <= (wr_en && wr_addr == cur_addr)  ? wr_data : mem[cur_addr];
        step_reg <= (wr_en && wr_addr == step_addr) ? wr_data : mem[step_addr];
        if (wr_en && wr_addr == '0)
        begin
            first_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

    assign count_dec = (count_reg == COUNT_MIN) ? count_reg : count_reg - 16'sd1;

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        fired      = 1'b0;
        if (tick && active)
        begin
            if (|(pad.pressed & mask))
            begin
                pos_next   = '0;
                count_next = first_reg;
            end
            else if (|(pad.held & mask))
            begin
                count_next = count_dec;
                if (count_dec <= 16'sd0)
                begin
                    fired = 1'b1;
                    if (pos_reg < LAST_POS && step_reg != END_MARK)
                    begin
                        pos_next   = pos_reg + PW'(1);
                        count_next = step_reg;
                    end
                    else
                    begin
                        count_next = cur_reg;
                    end
                end
            end
        end
    end

    assign cur_addr  = pos_next;
    assign step_addr = (pos_next < LAST_POS) ? pos_next + PW'(1) : pos_next;
endmodule

// ----- rtl/core/key_auto_repeat.sv -----
// Key auto-repeat for a 16-bit pad. Each item on cmd is either a tick carrying
// the held and newly pressed keys, or a write of one delay table entry. The block
// takes one item in every cycle unless a tick waits on an untaken result: an
// item is captured in an input register, all slots are updated in parallel as it
// leaves, and a tick's result is offered on res from the result register. Table
// writes give no result. Each slot keeps its delay table in a small memory whose
// two registered read ports always present the entries at and after the slot's
// position, so no tick waits on the memory. Registers are written over the APB
// port at byte addresses 0, 8 and 16 and should only be changed while idle.
module key_auto_repeat #(
    parameter int NUM_SLOTS   = kar_pkg::DEF_NUM_SLOTS,
    parameter int TABLE_DEPTH = kar_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    kar_cmd_if.sink                        cmd,
    kar_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kar_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kar_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kar_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import kar_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int SW = SLOT_IN_W + 1;

    cfg_t cfg;

    logic                      s1_valid_reg;
    op_t                       s1_op_reg;
    pad_t                      s1_pad_reg;
    logic [SLOT_IN_W-1:0]      s1_slot_reg;
    logic [POS_IN_W-1:0]       s1_pos_reg;
    logic signed [DELAY_W-1:0] s1_delay_reg;
    logic                      s1_adv;
    logic                      tick;
    logic                      wr_ok;
    logic [6:0]                pos_wide;
    logic [PW-1:0]             wr_addr;

    logic                      out_valid_reg;
    logic [KEY_W-1:0]          trigger_reg;
    logic [KEY_W-1:0]          repeat_reg;
    logic [KEY_W-1:0]          fired_keys;

    logic [NUM_SLOTS-1:0]      fired;
    logic [KEY_W-1:0]          slot_masks [NUM_SLOTS];

    kar_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A table write never needs the result register, so it always moves on.
    assign s1_adv    = s1_valid_reg && (s1_op_reg == OP_WRITE || !out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign tick      = s1_adv && s1_op_reg == OP_TICK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_op_reg          <= op_t'(cmd.op);
            s1_pad_reg.held    <= cmd.held_keys;
            s1_pad_reg.pressed <= cmd.pressed_keys;
            s1_slot_reg        <= cmd.entry_slot;
            s1_pos_reg         <= cmd.entry_position;
            s1_delay_reg       <= cmd.entry_delay;
        end
    end

    // Writes outside the slots or past the table depth are dropped.
    assign pos_wide = 7'(s1_pos_reg);
    assign wr_addr  = pos_wide[PW-1:0];
    assign wr_ok    = s1_adv && s1_op_reg == OP_WRITE
                   && SW'(s1_slot_reg) < SW'(NUM_SLOTS)
                   && pos_wide < 7'(TABLE_DEPTH);

    for (genvar s = 0; s < NUM_SLOTS; s++)
    begin : g_slot
        logic slot_active;

        if (s < REG_SLOTS - 1)
        begin : g_low
            assign slot_masks[s] = cfg.key_masks_low[KEY_W*s +: KEY_W];
        end
        else if (s == REG_SLOTS - 1)
        begin : g_last
            assign slot_masks[s] = cfg.key_mask_last;
        end
        else
        begin : g_none
            assign slot_masks[s] = '0;
        end

        if (s < REG_SLOTS)
        begin : g_en
            assign slot_active = cfg.slot_enable[s];
        end
        else
        begin : g_off
            assign slot_active = 1'b0;
        end

        kar_slot #(
            .TABLE_DEPTH (TABLE_DEPTH)
        ) u_slot (
            .clk     (clk),
            .rst_n   (rst_n),
            .tick    (tick),
            .active  (slot_active),
            .mask    (slot_masks[s]),
            .pad     (s1_pad_reg),
            .wr_en   (wr_ok && s1_slot_reg == SLOT_IN_W'(s)),
            .wr_addr (wr_addr),
            .wr_data (s1_delay_reg),
            .fired   (fired[s])
        );
    end

    always_comb
    begin
        fired_keys = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (fired[s])
            begin
                fired_keys = fired_keys | slot_masks[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            trigger_reg <= s1_pad_reg.pressed | fired_keys;
            repeat_reg  <= fired_keys;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.trigger_out = trigger_reg;
    assign res.repeat_keys = repeat_reg;
endmodule
